@@ rtl/cdq_pkg.sv @@
// Shared types, sizes, command and status codes for the circular deque.
package cdq_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  typedef logic [PTR_W-1:0]         ptr_t;
  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [CMD_W-1:0]         cmd_t;
  typedef logic [STAT_W-1:0]        stat_t;

  localparam cmd_t CMD_PUSH_BACK  = 3'd0;
  localparam cmd_t CMD_PUSH_FRONT = 3'd1;
  localparam cmd_t CMD_POP_BACK   = 3'd2;
  localparam cmd_t CMD_POP_FRONT  = 3'd3;
  localparam cmd_t CMD_QUERY      = 3'd4;

  localparam stat_t ST_OK        = 2'd0;
  localparam stat_t ST_OVERFLOW  = 2'd1;
  localparam stat_t ST_UNDERFLOW = 2'd2;

  localparam word_t EMPTY_WORD = '1;

  function automatic ptr_t ptr_inc(input ptr_t p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic ptr_t ptr_dec(input ptr_t p);
    if (p == '0) begin
      return PTR_W'(DEPTH - 1);
    end
    return p - 1'b1;
  endfunction

endpackage

@@ rtl/circular_deque_top.sv @@
// Circular deque top level: ring memory, pointer control and result register.
//
// A command passes through these steps from its acceptance to its result: in the
// accept cycle the pointers update and a push writes the ring memory, in the
// next cycle the words at the new head and tail are read, and in the last
// the result register loads, so a new command is taken only after that load.
// The ring memory read is registered, in a step of its own behind the write.
// A new command is accepted while an earlier result still waits
// in the output register; the block holds in its last step until
// the output register is free.
module circular_deque_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cdq_pkg::cmd_t   cmd,
  input  cdq_pkg::word_t  push_value,
  output logic            out_valid,
  input  logic            out_ready,
  output cdq_pkg::stat_t  status,
  output cdq_pkg::word_t  front_value,
  output cdq_pkg::word_t  back_value,
  output logic            empty_flag,
  output logic            full_flag
);
  import cdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  ptr_t  head, head_next;
  ptr_t  tail, tail_next;
  logic  vacant, vacant_next;
  stat_t stat, stat_next;

  logic  wr_en;
  ptr_t  wr_addr;
  logic  full_now;
  logic  accept;
  logic  load;

  word_t ring [DEPTH];
  word_t rd_front;
  word_t rd_back;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full_now = !vacant && (ptr_inc(tail) == head);
  assign load     = (state == S_LOAD) && (!out_valid || out_ready);

  always_comb begin
    head_next   = head;
    tail_next   = tail;
    vacant_next = vacant;
    stat_next   = ST_OK;
    wr_en       = 1'b0;
    wr_addr     = '0;
    case (cmd)
      CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
        if (full_now) begin
          stat_next = ST_OVERFLOW;
        end else if (vacant) begin
          head_next   = '0;
          tail_next   = '0;
          vacant_next = 1'b0;
          wr_en       = 1'b1;
          wr_addr     = '0;
        end else if (cmd == CMD_PUSH_BACK) begin
          tail_next = ptr_inc(tail);
          wr_en     = 1'b1;
          wr_addr   = ptr_inc(tail);
        end else begin
          head_next = ptr_dec(head);
          wr_en     = 1'b1;
          wr_addr   = ptr_dec(head);
        end
      end
      CMD_POP_BACK, CMD_POP_FRONT: begin
        if (vacant) begin
          stat_next = ST_UNDERFLOW;
        end else if (head == tail) begin
          head_next   = '0;
          tail_next   = '0;
          vacant_next = 1'b1;
        end else if (cmd == CMD_POP_BACK) begin
          tail_next = ptr_dec(tail);
        end else begin
          head_next = ptr_inc(head);
        end
      end
      default: begin
        if (vacant) begin
          stat_next = ST_UNDERFLOW;
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      vacant <= 1'b1;
    end else begin
      state <= state_next;
      if (accept) begin
        head   <= head_next;
        tail   <= tail_next;
        vacant <= vacant_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stat <= stat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      ring[wr_addr] <= push_value;
    end
    if (state == S_READ) begin
      rd_front <= ring[head];
      rd_back  <= ring[tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status      <= stat;
      front_value <= vacant ? EMPTY_WORD : rd_front;
      back_value  <= vacant ? EMPTY_WORD : rd_back;
      empty_flag  <= vacant;
      full_flag   <= full_now;
    end
  end

`ifndef SYNTHESIS
  a_vacant_ptrs: assert property (@(posedge clk) disable iff (rst)
    vacant |-> (head == '0) && (tail == '0))
    else $error("Empty deque with pointers away from slot zero.");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_READ))
    else $error("Accepted command did not move on to the memory read.");

  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_flag) |-> (front_value == EMPTY_WORD) && (back_value == EMPTY_WORD))
    else $error("Empty result carries ring words.");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_OVERFLOW)) |-> full_flag && !empty_flag)
    else $error("Overflow reported while the deque is not full.");
`endif

endmodule
